[rtl/skf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Shared constants, control word layout and the microcode table of the
// filter sequencer.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Gain is unsigned Q0.16; covariance carries four integer bits.
    localparam int GAIN_BITS    = 16;
    localparam int COV_INT_BITS = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    typedef logic [2:0] t_op;
    typedef logic [2:0] t_cond;
    typedef logic [2:0] t_pc;

    // Datapath operations.
    localparam t_op OP_NOP  = 3'd0;
    localparam t_op OP_WAIT = 3'd1;  // take a sample beat
    localparam t_op OP_PRED = 3'd2;  // p' = sat(p + q), innovation
    localparam t_op OP_DEN  = 3'd3;  // denominator, divider setup
    localparam t_op OP_DIV  = 3'd4;  // one restoring division step
    localparam t_op OP_SPEC = 3'd5;  // gain when r is zero
    localparam t_op OP_MUL  = 3'd6;  // correction and covariance products
    localparam t_op OP_WB   = 3'd7;  // update state, load result register

    // Jump conditions.
    localparam t_cond COND_NEXT   = 3'd0;
    localparam t_cond COND_ALWAYS = 3'd1;
    localparam t_cond COND_NOIN   = 3'd2;
    localparam t_cond COND_RZERO  = 3'd3;
    localparam t_cond COND_CNT    = 3'd4;
    localparam t_cond COND_ROOM   = 3'd5;

    // Program addresses.
    localparam t_pc PC_WAIT = 3'd0;
    localparam t_pc PC_PRED = 3'd1;
    localparam t_pc PC_DEN  = 3'd2;
    localparam t_pc PC_DIV  = 3'd3;
    localparam t_pc PC_MUL  = 3'd4;
    localparam t_pc PC_WB   = 3'd5;
    localparam t_pc PC_HOLD = 3'd6;
    localparam t_pc PC_SPEC = 3'd7;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // Microcode: a jump is taken when its condition holds, else the
    // program falls through to the next address.
    function automatic t_ctrl skf_rom(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_WAIT};
        unique case (pc)
            PC_WAIT: w = '{op: OP_WAIT, cond: COND_NOIN,   target: PC_WAIT};
            PC_PRED: w = '{op: OP_PRED, cond: COND_NEXT,   target: PC_WAIT};
            PC_DEN:  w = '{op: OP_DEN,  cond: COND_RZERO,  target: PC_SPEC};
            PC_DIV:  w = '{op: OP_DIV,  cond: COND_CNT,    target: PC_DIV};
            PC_MUL:  w = '{op: OP_MUL,  cond: COND_NEXT,   target: PC_WAIT};
            PC_WB:   w = '{op: OP_WB,   cond: COND_ROOM,   target: PC_WAIT};
            PC_HOLD: w = '{op: OP_NOP,  cond: COND_ALWAYS, target: PC_WB};
            PC_SPEC: w = '{op: OP_SPEC, cond: COND_ALWAYS, target: PC_MUL};
            default: w = '{op: OP_NOP,  cond: COND_ALWAYS, target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/skf_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scalar Kalman filter sample channel
// Valid/ready channel that carries one signed measurement per beat.
// ----------------------------------------------------------------------------
interface skf_in_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] measurement;

    modport source (output valid, output measurement, input ready);
    modport sink   (input valid, input measurement, output ready);
endinterface
`default_nettype wire

[rtl/skf_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scalar Kalman filter result channel
// Valid/ready channel that carries the filtered value and the gain per beat.
// ----------------------------------------------------------------------------
interface skf_out_if #(
    parameter int SAMPLE_WIDTH = 16
) ();
    import skf_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered_value;
    logic        [GAIN_BITS-1:0]    gain;

    modport source (output valid, output filtered_value, output gain, input ready);
    modport sink   (input valid, input filtered_value, input gain, output ready);
endinterface
`default_nettype wire

[rtl/scalar_kalman_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each sample beat runs prediction, denominator setup, the 16 shift-subtract
// steps of the gain divider (the unit-gain step when r is zero), multiply and
// writeback, which waits for room in the output; the next sample follows it.
// A finished result waits in the output register while the next sample is taken.
// Reset (synchronous, active low) clears estimate and covariance to zero and
// loads q = 0.003 and r = 0.5 in covariance format.
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// One-dimensional Kalman filter with A = H = 1, driven by a microcoded
// sequencer over a small fixed-point datapath.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COV_FRAC_BITS = 16
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]                  i_cfg_idx,
    input  wire logic [COV_FRAC_BITS+skf_pkg::COV_INT_BITS-1:0] i_cfg_data,
    skf_in_if.sink                                              i_in,
    skf_out_if.source                                           o_out
);
    import skf_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COV_FRAC_BITS + COV_INT_BITS;
    localparam int GB    = GAIN_BITS;
    localparam int PW    = SW + GB + 2;
    localparam int CPW   = CW + GB + 1;
    localparam int CNT_W = $clog2(GB);

    localparam int unsigned L_Q_RESET = ((3 << COV_FRAC_BITS) + 500) / 1000;
    localparam int unsigned L_R_RESET = 1 << (COV_FRAC_BITS - 1);

    localparam logic [PW-1:0]          L_HALF   = {{(PW-GB){1'b0}}, 1'b1, {(GB-1){1'b0}}};
    localparam logic [GB:0]            L_ONE    = {1'b1, {GB{1'b0}}};
    localparam logic signed [SW+1:0]   L_SMAX   = $signed({3'b000, {(SW-1){1'b1}}});
    localparam logic signed [SW+1:0]   L_SMIN   = $signed({3'b111, {(SW-1){1'b0}}});

    // Sequencer
    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;
    logic  w_take;
    logic  w_accept;
    logic  w_room;

    // State and configuration
    logic signed [SW-1:0] r_x;
    logic        [CW-1:0] r_p;
    logic        [CW-1:0] r_q;
    logic        [CW-1:0] r_r;

    // Datapath
    logic signed [SW-1:0]  r_meas;
    logic        [CW-1:0]  r_pp;
    logic signed [SW:0]    r_innov;
    logic        [CW:0]    r_den;
    logic        [CW:0]    r_rem;
    logic        [GB-1:0]  r_quo;
    logic        [CNT_W-1:0] r_cnt;
    logic signed [PW-1:0]  r_corr_prod;
    logic        [CPW-1:0] r_cov_prod;

    // Result register
    logic                 r_out_valid;
    logic signed [SW-1:0] r_out_val;
    logic        [GB-1:0] r_out_gain;

    logic        [CW:0]   w_pp_sum;
    logic        [CW-1:0] w_pp_sat;
    logic        [CW+1:0] w_rem_sh;
    logic        [CW+1:0] w_rem_diff;
    logic                 w_ge;
    logic        [GB:0]   w_gcomp;
    logic signed [PW-1:0] w_round;
    logic signed [PW-1:0] w_corr_full;
    logic signed [SW+1:0] w_sum;
    logic signed [SW-1:0] w_xn;

    assign w_ctrl   = skf_rom(r_pc);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_room   = !r_out_valid || o_out.ready;

    assign i_in.ready           = (w_ctrl.op == OP_WAIT);
    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_value = r_out_val;
    assign o_out.gain           = r_out_gain;

    always_comb begin
        unique case (w_ctrl.cond)
            COND_NEXT:   w_take = 1'b0;
            COND_ALWAYS: w_take = 1'b1;
            COND_NOIN:   w_take = !w_accept;
            COND_RZERO:  w_take = (r_r == '0);
            COND_CNT:    w_take = (r_cnt != '0);
            COND_ROOM:   w_take = w_room;
            default:     w_take = 1'b0;
        endcase
        n_pc = w_take ? w_ctrl.target : r_pc + t_pc'(1);
    end

    // Arithmetic
    always_comb begin
        w_pp_sum    = {1'b0, r_p} + {1'b0, r_q};
        w_pp_sat    = w_pp_sum[CW] ? '1 : w_pp_sum[CW-1:0];
        w_rem_sh    = {r_rem, 1'b0};
        w_rem_diff  = w_rem_sh - {1'b0, r_den};
        w_ge        = (w_rem_sh >= {1'b0, r_den});
        w_gcomp     = L_ONE - {1'b0, r_quo};
        // Round half up, then take the floor of the division by 2^16.
        w_round     = r_corr_prod + $signed(L_HALF);
        w_corr_full = w_round >>> GB;
        w_sum       = $signed({{2{r_x[SW-1]}}, r_x}) + $signed(w_corr_full[SW+1:0]);
        if (w_sum > L_SMAX) begin
            w_xn = L_SMAX[SW-1:0];
        end else if (w_sum < L_SMIN) begin
            w_xn = L_SMIN[SW-1:0];
        end else begin
            w_xn = w_sum[SW-1:0];
        end
    end

    // Control state, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_WAIT;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_p         <= '0;
            r_q         <= CW'(L_Q_RESET);
            r_r         <= CW'(L_R_RESET);
        end else begin
            r_pc <= n_pc;
            if (w_ctrl.op == OP_WB && w_room) begin
                r_out_valid <= 1'b1;
                r_x         <= w_xn;
                r_p         <= r_cov_prod[CW+GB-1:GB];
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PROCESS_NOISE) begin
                    r_q <= i_cfg_data;
                end else if (i_cfg_idx == REG_MEASUREMENT_NOISE) begin
                    r_r <= i_cfg_data;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (w_ctrl.op)
            OP_WAIT: begin
                if (w_accept) begin
                    r_meas <= i_in.measurement;
                end
            end
            OP_PRED: begin
                r_pp    <= w_pp_sat;
                r_innov <= $signed({r_meas[SW-1], r_meas}) - $signed({r_x[SW-1], r_x});
            end
            OP_DEN: begin
                r_den <= {1'b0, r_pp} + {1'b0, r_r};
                r_rem <= {1'b0, r_pp};
                r_quo <= '0;
                r_cnt <= CNT_W'(GB - 1);
            end
            OP_DIV: begin
                r_rem <= w_ge ? w_rem_diff[CW:0] : w_rem_sh[CW:0];
                r_quo <= {r_quo[GB-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_SPEC: begin
                // With r at zero the exact gain is one, held at the largest code; zero if p' is zero.
                r_quo <= (r_pp != '0) ? '1 : '0;
            end
            OP_MUL: begin
                r_corr_prod <= PW'($signed({1'b0, r_quo})) * PW'(r_innov);
                r_cov_prod  <= CPW'(r_pp) * CPW'(w_gcomp);
            end
            OP_WB: begin
                if (w_room) begin
                    r_out_val  <= w_xn;
                    r_out_gain <= r_quo;
                end
            end
            default: ;
        endcase
    end

    // Assertions
    a_div_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below denominator");

    a_spec_only_r_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_SPEC) |-> (r_den == {1'b0, r_pp}))
        else $error("unit-gain path taken with nonzero r");

    a_wb_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_WB && w_room) |=> (r_out_valid && r_pc == PC_WAIT))
        else $error("writeback did not present a result");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_pc == PC_PRED))
        else $error("sample beat did not start the program");

endmodule
`default_nettype wire
